[rtl/baro_sensor_compensation_assert.svh]
// Assertion macros shared by the compensation RTL.
// Each macro turns into nothing when SYNTHESIS is defined.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define BSC_ASSERT(lbl, clk, rst_n, prop)
`define BSC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/bsc_pkg.sv]
// Shared types, constants and coefficient helpers for the compensation block.
// No dependencies.
package bsc_pkg;

    localparam int RAW_W     = 20;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_C = 2'd3;

    localparam logic [63:0] TFINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_FULL   = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE  = 64'd3125;
    localparam logic [31:0] TEMP_ROUND   = 32'd128;
    localparam logic [63:0] P1_BIAS      = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] temp;
        logic [CFG_W-1:0] press_a;
        logic [CFG_W-1:0] press_b;
        logic [CFG_W-1:0] press_c;
    } t_coeffs;

    typedef struct packed {
        logic [31:0]      tfine;
        logic [31:0]      temp;
        logic [RAW_W-1:0] adp;
    } t_front_res;

    typedef struct packed {
        logic [31:0] temp;
        logic        zero;
    } t_div_tag;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        invalid;
    } t_result;

    // Signed 16-bit calibration word, sign-extended to 64 bits.
    function automatic logic [63:0] word_s(input logic [CFG_W-1:0] r, input int pos);
        logic [15:0] w;
        w = r[pos +: 16];
        return {{48{w[15]}}, w};
    endfunction

    // Unsigned 16-bit calibration word, zero-extended to 64 bits.
    function automatic logic [63:0] word_u(input logic [CFG_W-1:0] r, input int pos);
        logic [15:0] w;
        w = r[pos +: 16];
        return {48'd0, w};
    endfunction

endpackage

[rtl/bsc_mul64.sv]
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product.
// Built from three 32 by 32 partial products. No dependencies.
module bsc_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] n_ll;
    logic [31:0] n_hl;
    logic [31:0] n_lh;
    logic [63:0] r_ll;
    logic [31:0] r_hl;
    logic [31:0] r_lh;
    logic [63:0] r_p;

    // Partial products; the cross terms only matter in their low half.
    assign n_ll = i_a[31:0] * i_b[31:0];
    assign n_hl = i_a[63:32] * i_b[31:0];
    assign n_lh = i_a[31:0] * i_b[63:32];

    // First stage registers the partials, second stage sums them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_p  <= r_ll + {r_hl + r_lh, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

[rtl/bsc_front.sv]
// Front end: accepts raw beats and runs the 32-bit temperature path.
// Depends on bsc_pkg.
module bsc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [bsc_pkg::RAW_W-1:0] i_raw_temperature,
    input  logic [bsc_pkg::RAW_W-1:0] i_raw_pressure,
    input  bsc_pkg::t_coeffs         i_coeffs,
    output logic                     o_q_push,
    output bsc_pkg::t_front_res      o_q_data,
    input  logic                     i_q_full
);
    import bsc_pkg::*;

    logic [6:0]        r_vld;
    logic              w_adv;
    logic [RAW_W-1:0]  r_adp [7];
    logic [RAW_W-1:0]  r0_adt;
    logic signed [17:0] r1_d1;
    logic signed [16:0] r1_d2;
    logic signed [33:0] r2_pa;
    logic signed [33:0] r2_pb;
    logic signed [20:0] r3_a;
    logic signed [19:0] r3_bq;
    logic signed [20:0] r4_a;
    logic signed [35:0] r4_pc;
    logic [31:0]       r5_tfine;
    logic [31:0]       r6_tfine;
    logic [31:0]       r6_temp;
    logic [15:0]       w_t1;
    logic signed [15:0] w_t2;
    logic signed [15:0] w_t3;
    logic [17:0]       w_b;
    logic [31:0]       w_m;
    logic [31:0]       w_temp;

    assign w_t1 = i_coeffs.temp[15:0];
    assign w_t2 = i_coeffs.temp[31:16];
    assign w_t3 = i_coeffs.temp[47:32];

    // The whole front advances unless its last beat cannot enter the queue.
    assign w_adv    = !r_vld[6] || !i_q_full;
    assign o_full   = !w_adv;
    assign o_q_push = r_vld[6] && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[5:0], i_push};
        end
    end

    assign w_b    = r4_pc[31:14];
    assign w_m    = (r5_tfine << 2) + r5_tfine + TEMP_ROUND;
    assign w_temp = $signed(w_m) >>> 8;

    // Temperature stages; every intermediate wraps at 32 bits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_adt   <= i_raw_temperature;
            r_adp[0] <= i_raw_pressure;
            for (int k = 1; k < 7; k++) begin
                r_adp[k] <= r_adp[k-1];
            end
            r1_d1    <= {1'b0, r0_adt[19:3]} - {1'b0, w_t1, 1'b0};
            r1_d2    <= {1'b0, r0_adt[19:4]} - {1'b0, w_t1};
            r2_pa    <= r1_d1 * w_t2;
            r2_pb    <= r1_d2 * r1_d2;
            r3_a     <= r2_pa[31:11];
            r3_bq    <= r2_pb[31:12];
            r4_a     <= r3_a;
            r4_pc    <= r3_bq * w_t3;
            r5_tfine <= {{11{r4_a[20]}}, r4_a} + {{14{w_b[17]}}, w_b};
            r6_tfine <= r5_tfine;
            r6_temp  <= w_temp;
        end
    end

    assign o_q_data = '{tfine: r6_tfine, temp: r6_temp, adp: r_adp[6]};

endmodule

[rtl/bsc_mid_q.sv]
// Two-entry queue between the temperature front end and the pressure back end.
// Depends on bsc_pkg.
module bsc_mid_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bsc_pkg::t_front_res i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output bsc_pkg::t_front_res o_data
);
    import bsc_pkg::*;

    t_front_res r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data = r_mem[r_rp];

endmodule

[rtl/bsc_div.sv]
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on bsc_pkg. Stages run in order: the input stage, the restoring steps, the output stage.
module bsc_div (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [63:0]       i_num,
    input  logic [63:0]       i_den,
    input  bsc_pkg::t_div_tag i_tag,
    output logic [63:0]       o_quot,
    output bsc_pkg::t_div_tag o_tag
);
    import bsc_pkg::*;

    logic [63:0] r_n   [DIV_STEPS+1];
    logic [63:0] r_rem [DIV_STEPS];
    logic [63:0] r_d   [DIV_STEPS];
    logic        r_neg [DIV_STEPS+1];
    t_div_tag    r_tag [DIV_STEPS+1];
    logic [63:0] r_q;
    t_div_tag    r_tag_o;

    // Input stage: magnitudes and the sign of the quotient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_d[0]   <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_neg[0] <= i_num[63] ^ i_den[63];
            r_rem[0] <= 64'd0;
            r_tag[0] <= i_tag;
        end
    end

    // Restoring steps; the quotient bits shift in behind the dividend.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [64:0] w_sh;
        logic [64:0] w_diff;
        logic        w_bit;

        assign w_sh   = {r_rem[k], r_n[k][63]};
        assign w_diff = w_sh - {1'b0, r_d[k]};
        assign w_bit  = !w_diff[64];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= {r_n[k][62:0], w_bit};
                r_neg[k+1] <= r_neg[k];
                r_tag[k+1] <= r_tag[k];
            end
        end

        if (k < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_bit ? w_diff[63:0] : w_sh[63:0];
                    r_d[k+1]   <= r_d[k];
                end
            end
        end
    end

    // Output stage restores the sign.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q     <= r_neg[DIV_STEPS] ? (64'd0 - r_n[DIV_STEPS]) : r_n[DIV_STEPS];
            r_tag_o <= r_tag[DIV_STEPS];
        end
    end

    assign o_quot = r_q;
    assign o_tag  = r_tag_o;

endmodule

[rtl/bsc_back.sv]
// Back end: 64-bit pressure path, divider and the result queue.
// Depends on bsc_pkg, bsc_mul64, bsc_div and the assertion macro header.
`include "baro_sensor_compensation_assert.svh"
module bsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsc_pkg::t_coeffs    i_coeffs,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  bsc_pkg::t_front_res i_q_data,
    output logic                o_empty,
    input  logic                i_pop,
    output bsc_pkg::t_result    o_result
);
    import bsc_pkg::*;

    localparam int LAST = 80;

    logic [LAST:0]    r_vld;
    logic             w_adv;
    logic [63:0]      w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [63:0]      r0_v1;
    logic [31:0]      r_temp [9];
    logic [RAW_W-1:0] r_adp [6];
    logic [63:0]      w_x, w_y5, w_y2, w_xp6, w_xp3;
    logic [63:0]      r_y5_3, r_y5_4, r_y2_3, r_y2_4;
    logic [63:0]      w_xp3_s;
    logic [63:0]      r5_v2, r5_v1b;
    logic [63:0]      r6_w, r6_t;
    logic [63:0]      w_m3, w_num, w_den;
    t_div_tag         w_dtag_in;
    logic [63:0]      w_q;
    t_div_tag         w_dtag;
    logic [63:0]      w_qs;
    logic [63:0]      w_q9, w_q8, w_q99;
    logic [63:0]      r_qs_75, r_qs_76, r_q8_77, r_q8_78;
    logic [63:0]      r_q_d [4];
    t_div_tag         r_tag_d [4];
    logic [63:0]      w_q99_s, w_q8_s;
    logic [63:0]      r79_sum;
    t_div_tag         r79_tag;
    logic [63:0]      w_sum_s, w_p;
    t_result          r_res;
    t_result          r_oq [2];
    logic             r_oq_wp, r_oq_rp;
    logic [1:0]       r_oq_cnt;
    logic             w_oq_full, w_oq_push, w_oq_pop;

    assign w_p1 = word_u(i_coeffs.press_a, 0);
    assign w_p2 = word_s(i_coeffs.press_a, 16);
    assign w_p3 = word_s(i_coeffs.press_a, 32);
    assign w_p4 = word_s(i_coeffs.press_b, 0);
    assign w_p5 = word_s(i_coeffs.press_b, 16);
    assign w_p6 = word_s(i_coeffs.press_b, 32);
    assign w_p7 = word_s(i_coeffs.press_c, 0);
    assign w_p8 = word_s(i_coeffs.press_c, 16);
    assign w_p9 = word_s(i_coeffs.press_c, 32);

    // The pipeline moves as one unless its finished beat has nowhere to go.
    assign w_adv   = !r_vld[LAST] || !w_oq_full;
    assign o_q_pop = w_adv && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAST-1:0], o_q_pop};
        end
    end

    // Products of the offset fine temperature.
    bsc_mul64 u_x   (.i_clk, .i_en(w_adv), .i_a(r0_v1), .i_b(r0_v1), .o_p(w_x));
    bsc_mul64 u_y5  (.i_clk, .i_en(w_adv), .i_a(r0_v1), .i_b(w_p5),  .o_p(w_y5));
    bsc_mul64 u_y2  (.i_clk, .i_en(w_adv), .i_a(r0_v1), .i_b(w_p2),  .o_p(w_y2));
    bsc_mul64 u_xp6 (.i_clk, .i_en(w_adv), .i_a(w_x),   .i_b(w_p6),  .o_p(w_xp6));
    bsc_mul64 u_xp3 (.i_clk, .i_en(w_adv), .i_a(w_x),   .i_b(w_p3),  .o_p(w_xp3));

    assign w_xp3_s = $signed(w_xp3) >>> 8;

    // Divisor product and scaled numerator.
    bsc_mul64 u_v1c   (.i_clk, .i_en(w_adv), .i_a(r6_w), .i_b(w_p1),        .o_p(w_m3));
    bsc_mul64 u_scale (.i_clk, .i_en(w_adv), .i_a(r6_t), .i_b(PRESS_SCALE), .o_p(w_num));

    assign w_den     = $signed(w_m3) >>> 33;
    assign w_dtag_in = '{temp: r_temp[8], zero: (w_den == 64'd0)};

    bsc_div u_div (
        .i_clk,
        .i_en   (w_adv),
        .i_num  (w_num),
        .i_den  (w_den),
        .i_tag  (w_dtag_in),
        .o_quot (w_q),
        .o_tag  (w_dtag)
    );

    // Second-order correction products on the quotient.
    assign w_qs = $signed(w_q) >>> 13;

    bsc_mul64 u_q9  (.i_clk, .i_en(w_adv), .i_a(w_p9), .i_b(w_qs),    .o_p(w_q9));
    bsc_mul64 u_q8  (.i_clk, .i_en(w_adv), .i_a(w_p8), .i_b(w_q),     .o_p(w_q8));
    bsc_mul64 u_q99 (.i_clk, .i_en(w_adv), .i_a(w_q9), .i_b(r_qs_76), .o_p(w_q99));

    assign w_q99_s = $signed(w_q99) >>> 25;
    assign w_q8_s  = $signed(r_q8_78) >>> 19;
    assign w_sum_s = $signed(r79_sum) >>> 8;
    assign w_p     = w_sum_s + (w_p7 << 4);

    // Data stages around the multipliers and the divider, and the final result stage.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_v1     <= {{32{i_q_data.tfine[31]}}, i_q_data.tfine} - TFINE_OFFSET;
            r_temp[0] <= i_q_data.temp;
            r_adp[0]  <= i_q_data.adp;
            for (int k = 1; k < 9; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                r_adp[k] <= r_adp[k-1];
            end
            r_y5_3  <= w_y5;
            r_y5_4  <= r_y5_3;
            r_y2_3  <= w_y2;
            r_y2_4  <= r_y2_3;
            r5_v2   <= w_xp6 + (r_y5_4 << 17) + (w_p4 << 35);
            r5_v1b  <= w_xp3_s + (r_y2_4 << 12);
            r6_w    <= P1_BIAS + r5_v1b;
            r6_t    <= ((PRESS_FULL - {44'd0, r_adp[5]}) << 31) - r5_v2;
            r_qs_75 <= w_qs;
            r_qs_76 <= r_qs_75;
            r_q8_77 <= w_q8;
            r_q8_78 <= r_q8_77;
            r_q_d[0]   <= w_q;
            r_tag_d[0] <= w_dtag;
            for (int k = 1; k < 4; k++) begin
                r_q_d[k]   <= r_q_d[k-1];
                r_tag_d[k] <= r_tag_d[k-1];
            end
            r79_sum <= r_q_d[3] + w_q99_s + w_q8_s;
            r79_tag <= r_tag_d[3];
            r_res.temp    <= r79_tag.temp;
            r_res.press   <= r79_tag.zero ? 32'd0 : w_p[31:0];
            r_res.invalid <= r79_tag.zero;
        end
    end

    // Result queue, two beats deep.
    assign w_oq_full = (r_oq_cnt == 2'd2);
    assign o_empty   = (r_oq_cnt == 2'd0);
    assign w_oq_push = w_adv && r_vld[LAST];
    assign w_oq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_oq_push) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (w_oq_pop) begin
                r_oq_rp <= !r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, w_oq_push} - {1'b0, w_oq_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_oq_wp] <= r_res;
        end
    end

    assign o_result = r_oq[r_oq_rp];

    // A stalled finished beat keeps its value until the queue takes it.
    `BSC_ASSERT(a_stall_hold, i_clk, i_rst_n, (r_vld[LAST] && !w_adv) |=> (r_vld[LAST] && $stable(r_res)))
    // A zero divisor always yields zero pressure.
    `BSC_ASSERT(a_invalid_zero, i_clk, i_rst_n, (r_vld[LAST] && r_res.invalid) |-> (r_res.press == 32'd0))
    // A beat written into the queue is visible on the next cycle.
    `BSC_ASSERT(a_push_seen, i_clk, i_rst_n, (w_oq_push && !w_oq_pop) |=> !o_empty)
    // The fill count never passes the queue depth.
    `BSC_ASSERT_NEVER(a_oq_bound, i_clk, i_rst_n, r_oq_cnt == 2'd3)

endmodule

[rtl/baro_sensor_compensation.sv]
// Top level of the barometric temperature and pressure compensation block.
// Depends on bsc_pkg, bsc_front, bsc_mid_q, bsc_back.
//
// One raw temperature and pressure pair is taken per beat and one compensated
// result comes back per beat, in order. The block is fully pipelined and takes
// a new pair every clock cycle as long as results are popped; the pipeline
// depth is set mostly by the 64 restoring stages of the divider (one quotient
// bit per stage) and the 64-bit multipliers of the pressure path. A full queue
// at the output stalls the pressure pipeline, and a full queue in the middle
// stalls the temperature front, which raises full. Calibration registers are
// written directly and must only change while no beat is in flight.
module baro_sensor_compensation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [bsc_pkg::RAW_W-1:0]    i_raw_temperature,
    input  logic [bsc_pkg::RAW_W-1:0]    i_raw_pressure,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [31:0]           o_temperature_centi,
    output logic [31:0]                  o_pressure_q24_8,
    output logic                         o_pressure_invalid,
    input  logic                         i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsc_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import bsc_pkg::*;

    t_coeffs    r_coeffs;
    logic       w_mq_push;
    t_front_res w_mq_in;
    logic       w_mq_full;
    logic       w_mq_pop;
    logic       w_mq_empty;
    t_front_res w_mq_out;
    t_result    w_result;

    // Calibration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEMP:    r_coeffs.temp    <= i_cfg_wdata;
                REG_PRESS_A: r_coeffs.press_a <= i_cfg_wdata;
                REG_PRESS_B: r_coeffs.press_b <= i_cfg_wdata;
                REG_PRESS_C: r_coeffs.press_c <= i_cfg_wdata;
                default:     r_coeffs         <= r_coeffs;
            endcase
        end
    end

    bsc_front u_front (
        .i_clk,
        .i_rst_n,
        .i_push            (push),
        .o_full            (full),
        .i_raw_temperature,
        .i_raw_pressure,
        .i_coeffs          (r_coeffs),
        .o_q_push          (w_mq_push),
        .o_q_data          (w_mq_in),
        .i_q_full          (w_mq_full)
    );

    bsc_mid_q u_mid_q (
        .i_clk,
        .i_rst_n,
        .i_push  (w_mq_push),
        .i_data  (w_mq_in),
        .o_full  (w_mq_full),
        .i_pop   (w_mq_pop),
        .o_empty (w_mq_empty),
        .o_data  (w_mq_out)
    );

    bsc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_coeffs  (r_coeffs),
        .i_q_empty (w_mq_empty),
        .o_q_pop   (w_mq_pop),
        .i_q_data  (w_mq_out),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (w_result)
    );

    assign o_temperature_centi = w_result.temp;
    assign o_pressure_q24_8    = w_result.press;
    assign o_pressure_invalid  = w_result.invalid;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for baro_sensor_compensation: directed table, then random phases.
// Depends on bsc_pkg and the compensation RTL; it predicts or types in each result and compares in order.
`timescale 1ns / 1ps

module tb_top;
    import bsc_pkg::*;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        invalid;
    } t_reading;

    typedef struct {
        int          setting;
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        bit          typed;
        t_reading    want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [RAW_W-1:0]      i_raw_temperature = '0;
    logic [RAW_W-1:0]      i_raw_pressure = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic signed [31:0]    o_temperature_centi;
    logic [31:0]           o_pressure_q24_8;
    logic                  o_pressure_invalid;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_TEMP;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    logic [CFG_W-1:0]      coef [4];
    t_reading              pending_readings [$];
    int                    errors = 0;
    bit                    calm = 1'b0;
    t_row                  rows [$];

    baro_sensor_compensation u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_raw_temperature   (i_raw_temperature),
        .i_raw_pressure      (i_raw_pressure),
        .empty               (empty),
        .pop                 (pop),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_pressure_invalid  (o_pressure_invalid),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Generous fixed limit on the whole run.
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // Integer compensation: 32-bit temperature path, 64-bit pressure path.
    function automatic t_reading compensate(logic [19:0] raw_t, logic [19:0] raw_p);
        logic signed [31:0] t1, t2, t3, d, a, b, tf;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x, y, num, pr;
        t_reading r;
        t1 = {16'd0, coef[REG_TEMP][15:0]};
        t2 = {{16{coef[REG_TEMP][31]}}, coef[REG_TEMP][31:16]};
        t3 = {{16{coef[REG_TEMP][47]}}, coef[REG_TEMP][47:32]};
        p1 = {48'd0, coef[REG_PRESS_A][15:0]};
        p2 = {{48{coef[REG_PRESS_A][31]}}, coef[REG_PRESS_A][31:16]};
        p3 = {{48{coef[REG_PRESS_A][47]}}, coef[REG_PRESS_A][47:32]};
        p4 = {{48{coef[REG_PRESS_B][15]}}, coef[REG_PRESS_B][15:0]};
        p5 = {{48{coef[REG_PRESS_B][31]}}, coef[REG_PRESS_B][31:16]};
        p6 = {{48{coef[REG_PRESS_B][47]}}, coef[REG_PRESS_B][47:32]};
        p7 = {{48{coef[REG_PRESS_C][15]}}, coef[REG_PRESS_C][15:0]};
        p8 = {{48{coef[REG_PRESS_C][31]}}, coef[REG_PRESS_C][31:16]};
        p9 = {{48{coef[REG_PRESS_C][47]}}, coef[REG_PRESS_C][47:32]};

        // Temperature path and the fine-temperature term.
        d = {15'd0, raw_t[19:3]} - (t1 <<< 1);
        a = (d * t2) >>> 11;
        d = {16'd0, raw_t[19:4]} - t1;
        b = (d * d) >>> 12;
        b = (b * t3) >>> 14;
        tf = a + b;
        r.temp = (tf * 32'sd5 + 32'sd128) >>> 8;

        // Pressure path: divisor first, then the quotient and its corrections.
        x = 64'(tf);
        x = x - 64'sd128000;
        y = x * x * p6;
        y = y + ((x * p5) <<< 17);
        y = y + (p4 <<< 35);
        x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
        x = ((64'sh0000_8000_0000_0000 + x) * p1) >>> 33;
        if (x == 64'sd0) begin
            r.press = 32'd0;
            r.invalid = 1'b1;
            return r;
        end
        pr = 64'sd1048576;
        pr = pr - $signed({44'd0, raw_p});
        num = ((pr <<< 31) - y) * 64'sd3125;
        // The one overflowing quotient wraps to the most negative value.
        if (num == 64'sh8000_0000_0000_0000 && x == -64'sd1) begin
            pr = num;
        end else begin
            pr = num / x;
        end
        x = (p9 * (pr >>> 13) * (pr >>> 13)) >>> 25;
        y = (p8 * pr) >>> 19;
        pr = ((pr + x + y) >>> 8) + (p7 <<< 4);
        r.press = pr[31:0];
        r.invalid = 1'b0;
        return r;
    endfunction

    // Waits until every expected reading has come back, then a short margin.
    task automatic drain();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes all four calibration registers with the block idle.
    task automatic load_coeffs(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                               logic [47:0] pc);
        logic [47:0] vals [4];
        vals[REG_TEMP] = tc;
        vals[REG_PRESS_A] = pa;
        vals[REG_PRESS_B] = pb;
        vals[REG_PRESS_C] = pc;
        drain();
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(i);
            i_cfg_wdata <= vals[i];
            coef[i] = vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Named calibration sets used by the table and the random phases.
    task automatic load_setting(int s);
        case (s)
            0: begin
                load_coeffs('0, '0, '0, '0);
            end
            1: begin
                load_coeffs(48'hFC18_6743_6B70, 48'h0BD0_D643_8E7D,
                            48'hFFF9_008C_0B27, 48'h1770_C6F8_3C8C);
            end
            2: begin
                load_coeffs(48'hFC18_6743_6B70, 48'h0BD0_D643_0000,
                            48'hFFF9_008C_0B27, 48'h1770_C6F8_3C8C);
            end
            3: begin
                load_coeffs('1, '1, '1, '1);
            end
            4: begin
                load_coeffs(48'h8000_7FFF_FFFF, 48'h7FFF_8000_FFFF,
                            48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF);
            end
            default: begin
                load_coeffs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            end
        endcase
    endtask

    // Sends one beat, optionally after an idle gap, and records its prediction.
    task automatic send(logic [19:0] raw_t, logic [19:0] raw_p, bit typed, t_reading want);
        if (!calm && $urandom_range(99) < 23) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure <= raw_p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_readings.push_back(typed ? want : compensate(raw_t, raw_p));
    endtask

    // Result side: random stalls, and an in-order check on every popped beat.
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && pop && !empty) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected beat temp=%0d press=%h inv=%b", $time,
                         o_temperature_centi, o_pressure_q24_8, o_pressure_invalid);
                errors++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (o_temperature_centi !== exp_r.temp) begin
                    $display("%0t: temperature expected %0d got %0d", $time,
                             $signed(exp_r.temp), o_temperature_centi);
                    errors++;
                end
                if (o_pressure_q24_8 !== exp_r.press) begin
                    $display("%0t: pressure expected %h got %h", $time,
                             exp_r.press, o_pressure_q24_8);
                    errors++;
                end
                if (o_pressure_invalid !== exp_r.invalid) begin
                    $display("%0t: invalid flag expected %b got %b", $time,
                             exp_r.invalid, o_pressure_invalid);
                    errors++;
                end
            end
        end
        pop <= calm || ($urandom_range(99) >= 23);
    end

    // Adds one directed row; the reading is typed in only where it is obvious.
    task automatic add_row(int s, logic [19:0] rt, logic [19:0] rp, bit typed);
        t_row r;
        r.setting = s;
        r.raw_t = rt;
        r.raw_p = rp;
        r.typed = typed;
        r.want = '{temp: 32'd0, press: 32'd0, invalid: 1'b1};
        rows.push_back(r);
    endtask

    initial begin
        int cur;
        logic [19:0] rt, rp;
        for (int i = 0; i < 4; i++) coef[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset every coefficient is zero: temperature 0, divisor 0.
        add_row(0, 20'h00000, 20'h00000, 1);
        add_row(0, 20'hFFFFF, 20'hFFFFF, 1);
        add_row(0, 20'h00000, 20'hFFFFF, 1);
        add_row(0, 20'hFFFFF, 20'h00000, 1);
        add_row(0, 20'h80000, 20'h55555, 1);
        // Typical calibration, with the usual sample pair and the extremes.
        add_row(1, 20'd519888, 20'd415148, 0);
        add_row(1, 20'h00000, 20'h00000, 0);
        add_row(1, 20'hFFFFF, 20'hFFFFF, 0);
        add_row(1, 20'hAAAAA, 20'h55555, 0);
        add_row(1, 20'h55555, 20'hAAAAA, 0);
        // Zero P1 gives a zero divisor with a valid temperature.
        add_row(2, 20'd519888, 20'd415148, 0);
        add_row(2, 20'hFFFFF, 20'h00000, 0);
        // Coefficient extremes, which wrap the intermediates.
        add_row(3, 20'h00000, 20'hFFFFF, 0);
        add_row(3, 20'hFFFFF, 20'h00000, 0);
        add_row(3, 20'd519888, 20'd415148, 0);
        add_row(4, 20'h00000, 20'h00000, 0);
        add_row(4, 20'hFFFFF, 20'hFFFFF, 0);
        add_row(4, 20'h7FFFF, 20'h80000, 0);

        cur = 0;
        foreach (rows[i]) begin
            if (rows[i].setting != cur) begin
                cur = rows[i].setting;
                push <= 1'b0;
                load_setting(cur);
            end
            send(rows[i].raw_t, rows[i].raw_p, rows[i].typed, rows[i].want);
        end

        // Random phases: the sender pauses for a full drain before each new setting.
        for (int ph = 0; ph < 8; ph++) begin
            push <= 1'b0;
            load_setting(ph < 5 ? ph : 5 + ph);
            calm = (ph == 3);
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(1)) begin
                    rt = 20'd519888 + 20'($urandom_range(0, 65535)) - 20'd32768;
                    rp = 20'd415148 + 20'($urandom_range(0, 131071)) - 20'd65536;
                end else begin
                    rt = 20'($urandom);
                    rp = 20'($urandom);
                end
                send(rt, rp, 0, '0);
            end
            calm = 1'b0;
        end
        push <= 1'b0;
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
